// ===== src/sbag_pkg.sv =====
`timescale 1ns / 1ps
package sbag_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int MAX_DIMENSION = 1024;

  localparam int DIM_W   = 11;
  localparam int COORD_W = 10;
  localparam int POS_W   = DIM_W + FRACTION_BITS;
  localparam int IDX_W   = 20;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int DIV_CNT_W = $clog2(POS_W + 1);

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_SRC_TEX_W = 2'd0;
  localparam logic [1:0] REG_SRC_TEX_H = 2'd1;
  localparam logic [1:0] REG_DST_TEX_W = 2'd2;
  localparam logic [1:0] REG_DST_TEX_H = 2'd3;

  typedef enum logic [1:0] {
    ST_PAIR     = 2'd0,
    ST_START_OK = 2'd1,
    ST_REJECT   = 2'd2,
    ST_NO_BLIT  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DIVIDE
  } state_t;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic reject;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_bad;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/scaled_blit_address_generator_unit.sv =====
`timescale 1ns / 1ps
// an advance or a rejected start shows its result from the registered output
// an accepted start shows its result once both step dividers are done and the output is free
// throughput: one advance transaction per cycle unless the output stalls; a start holds the
// input off until its result is loaded (bit-serial step dividers, one quotient bit per cycle)
// reset: synchronous, active low; texture registers return to 320x240, no blit active
module scaled_blit_address_generator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_src_x,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_src_y,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_src_w,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_src_h,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_dst_x,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_dst_y,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_dst_w,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_dst_h,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [sbag_pkg::IDX_W-1:0]    out_source_index,
  output logic [sbag_pkg::IDX_W-1:0]    out_target_index,
  output logic                          out_last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbag_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbag_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbag_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import sbag_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // texture size registers, clamped to the largest dimension on write
  sbag_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: takes a transaction when the output register is free,
  // holds the input off while the step division of a start runs
  sbag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath: bounds check, step dividers, raster walk, index multipliers
  // and the output payload register
  sbag_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg              (cfg),
    .in_rect_src_x    (in_rect_src_x),
    .in_rect_src_y    (in_rect_src_y),
    .in_rect_src_w    (in_rect_src_w),
    .in_rect_src_h    (in_rect_src_h),
    .in_rect_dst_x    (in_rect_dst_x),
    .in_rect_dst_y    (in_rect_dst_y),
    .in_rect_dst_w    (in_rect_dst_w),
    .in_rect_dst_h    (in_rect_dst_h),
    .out_status       (out_status),
    .out_source_index (out_source_index),
    .out_target_index (out_target_index),
    .out_last         (out_last)
  );

endmodule

// ===== src/sbag_regs.sv =====
`timescale 1ns / 1ps
module sbag_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbag_pkg::PADDR_W-1:0]  paddr,
  input  logic [sbag_pkg::PDATA_W-1:0]  pwdata,
  output logic [sbag_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output sbag_pkg::cfg_t                cfg
);
  import sbag_pkg::*;

  cfg_t             cfg_r, cfg_nxt;
  logic [DIM_W-1:0] wr_val;
  logic [DIM_W-1:0] rd_val;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // values above the largest dimension clamp to it
  always_comb begin
    wr_val = pwdata[DIM_W-1:0];
    if (wr_val > DIM_W'(MAX_DIMENSION)) begin
      wr_val = DIM_W'(MAX_DIMENSION);
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_SRC_TEX_W: cfg_nxt.src_w = wr_val;
        REG_SRC_TEX_H: cfg_nxt.src_h = wr_val;
        REG_DST_TEX_W: cfg_nxt.dst_w = wr_val;
        REG_DST_TEX_H: cfg_nxt.dst_h = wr_val;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_TEX_W: rd_val = cfg_r.src_w;
      REG_SRC_TEX_H: rd_val = cfg_r.src_h;
      REG_DST_TEX_W: rd_val = cfg_r.dst_w;
      REG_DST_TEX_H: rd_val = cfg_r.dst_h;
      default:       rd_val = '0;
    endcase
  end

  assign prdata = PDATA_W'(rd_val);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w <= DIM_W'(320);
      cfg_r.src_h <= DIM_W'(240);
      cfg_r.dst_w <= DIM_W'(320);
      cfg_r.dst_h <= DIM_W'(240);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/sbag_div.sv =====
`timescale 1ns / 1ps
module sbag_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sbag_pkg::POS_W-1:0]  dividend,
  input  logic [sbag_pkg::DIM_W-1:0]  divisor,
  output logic [sbag_pkg::POS_W-1:0]  quotient,
  output logic                        done
);
  import sbag_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIM_W-1:0]     rem_r, rem_nxt;
  logic [POS_W-1:0]     quo_r, quo_nxt;
  logic [DIM_W-1:0]     div_r, div_nxt;
  logic [DIM_W:0]       trial;
  logic [DIM_W:0]       diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[POS_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};
  assign done  = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(POS_W);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (!done) begin
      cnt_nxt = cnt_r - 1'b1;
      rem_nxt = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
      quo_nxt = {quo_r[POS_W-2:0], ge};
    end
  end

  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
      div_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      div_r <= div_nxt;
    end
  end

endmodule

// ===== src/sbag_dp.sv =====
`timescale 1ns / 1ps
module sbag_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbag_pkg::ctrl_cmd_t           cmd,
  output sbag_pkg::dp_status_t          status,
  input  sbag_pkg::cfg_t                cfg,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_src_x,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_src_y,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_src_w,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_src_h,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_dst_x,
  input  logic [sbag_pkg::COORD_W-1:0]  in_rect_dst_y,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_dst_w,
  input  logic [sbag_pkg::DIM_W-1:0]    in_rect_dst_h,
  output logic [1:0]                    out_status,
  output logic [sbag_pkg::IDX_W-1:0]    out_source_index,
  output logic [sbag_pkg::IDX_W-1:0]    out_target_index,
  output logic                          out_last
);
  import sbag_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [POS_W-1:0]     pos_x_r, pos_x_nxt;
  logic [POS_W-1:0]     pos_y_r, pos_y_nxt;
  logic [COORD_W-1:0]   origin_x_r, origin_x_nxt;
  logic [COORD_W-1:0]   tgt_org_x_r, tgt_org_x_nxt;
  logic [COORD_W-1:0]   tgt_org_y_r, tgt_org_y_nxt;
  logic [DIM_W-1:0]     tgt_cols_r, tgt_cols_nxt;
  logic [DIM_W-1:0]     tgt_rows_r, tgt_rows_nxt;
  logic [DIM_W-1:0]     col_cnt_r, col_cnt_nxt;
  logic [DIM_W-1:0]     row_cnt_r, row_cnt_nxt;

  status_t              o_status_r, o_status_nxt;
  logic [IDX_W-1:0]     o_src_r, o_src_nxt;
  logic [IDX_W-1:0]     o_dst_r, o_dst_nxt;
  logic                 o_last_r, o_last_nxt;

  logic [POS_W-1:0]     step_x, step_y;
  logic                 done_x, done_y;

  logic [DIM_W:0]       sum_sx, sum_sy, sum_dx, sum_dy;
  logic [DIM_W-1:0]     src_row, src_col;
  logic [2*DIM_W-1:0]   src_prod;
  logic [IDX_W-1:0]     src_idx;
  logic [DIM_W:0]       dst_row;
  logic [2*DIM_W:0]     dst_prod;
  logic [IDX_W-1:0]     dst_idx;
  logic [DIM_W-1:0]     col_inc, row_inc;
  logic                 row_end, blit_end;

  sbag_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend ({in_rect_src_w, FRACTION_BITS'(0)}),
    .divisor  (in_rect_dst_w),
    .quotient (step_x),
    .done     (done_x)
  );

  sbag_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend ({in_rect_src_h, FRACTION_BITS'(0)}),
    .divisor  (in_rect_dst_h),
    .quotient (step_y),
    .done     (done_y)
  );

  // bounds check of a start
  assign sum_sx = {2'b0, in_rect_src_x} + {1'b0, in_rect_src_w};
  assign sum_sy = {2'b0, in_rect_src_y} + {1'b0, in_rect_src_h};
  assign sum_dx = {2'b0, in_rect_dst_x} + {1'b0, in_rect_dst_w};
  assign sum_dy = {2'b0, in_rect_dst_y} + {1'b0, in_rect_dst_h};

  assign status.start_bad = (sum_sx > {1'b0, cfg.src_w}) || (sum_sy > {1'b0, cfg.src_h}) ||
                            (sum_dx > {1'b0, cfg.dst_w}) || (sum_dy > {1'b0, cfg.dst_h}) ||
                            (in_rect_dst_w == '0) || (in_rect_dst_h == '0);
  assign status.div_done  = done_x && done_y;

  // address pair of the current pixel
  assign src_row  = pos_y_r[POS_W-1:FRACTION_BITS];
  assign src_col  = pos_x_r[POS_W-1:FRACTION_BITS];
  assign src_prod = (2*DIM_W)'(src_row) * (2*DIM_W)'(cfg.src_w);
  assign src_idx  = src_prod[IDX_W-1:0] + IDX_W'(src_col);

  assign dst_row  = {2'b0, tgt_org_y_r} + {1'b0, row_cnt_r};
  assign dst_prod = (2*DIM_W+1)'(dst_row) * (2*DIM_W+1)'(cfg.dst_w);
  assign dst_idx  = dst_prod[IDX_W-1:0] + IDX_W'(tgt_org_x_r) + IDX_W'(col_cnt_r);

  assign col_inc  = col_cnt_r + 1'b1;
  assign row_inc  = row_cnt_r + 1'b1;
  assign row_end  = col_inc >= tgt_cols_r;
  assign blit_end = row_end && (row_inc >= tgt_rows_r);

  always_comb begin
    busy_nxt      = busy_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    origin_x_nxt  = origin_x_r;
    tgt_org_x_nxt = tgt_org_x_r;
    tgt_org_y_nxt = tgt_org_y_r;
    tgt_cols_nxt  = tgt_cols_r;
    tgt_rows_nxt  = tgt_rows_r;
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    o_status_nxt  = o_status_r;
    o_src_nxt     = o_src_r;
    o_dst_nxt     = o_dst_r;
    o_last_nxt    = o_last_r;

    if (cmd.reject) begin
      busy_nxt     = 1'b0;
      o_status_nxt = ST_REJECT;
      o_src_nxt    = '0;
      o_dst_nxt    = '0;
      o_last_nxt   = 1'b0;
    end

    if (cmd.capture) begin
      busy_nxt      = 1'b0;
      origin_x_nxt  = in_rect_src_x;
      pos_x_nxt     = POS_W'({in_rect_src_x, FRACTION_BITS'(0)});
      pos_y_nxt     = POS_W'({in_rect_src_y, FRACTION_BITS'(0)});
      tgt_org_x_nxt = in_rect_dst_x;
      tgt_org_y_nxt = in_rect_dst_y;
      tgt_cols_nxt  = in_rect_dst_w;
      tgt_rows_nxt  = in_rect_dst_h;
      col_cnt_nxt   = '0;
      row_cnt_nxt   = '0;
    end

    if (cmd.commit) begin
      busy_nxt     = 1'b1;
      o_status_nxt = ST_START_OK;
      o_src_nxt    = '0;
      o_dst_nxt    = '0;
      o_last_nxt   = 1'b0;
    end

    if (cmd.advance) begin
      if (!busy_r) begin
        o_status_nxt = ST_NO_BLIT;
        o_src_nxt    = '0;
        o_dst_nxt    = '0;
        o_last_nxt   = 1'b0;
      end else begin
        o_status_nxt = ST_PAIR;
        o_src_nxt    = src_idx;
        o_dst_nxt    = dst_idx;
        o_last_nxt   = blit_end;
        if (row_end) begin
          col_cnt_nxt = '0;
          pos_x_nxt   = POS_W'({origin_x_r, FRACTION_BITS'(0)});
          row_cnt_nxt = row_inc;
          pos_y_nxt   = pos_y_r + step_y;
          busy_nxt    = !blit_end;
        end else begin
          col_cnt_nxt = col_inc;
          pos_x_nxt   = pos_x_r + step_x;
        end
      end
    end
  end

  assign out_status       = o_status_r;
  assign out_source_index = o_src_r;
  assign out_target_index = o_dst_r;
  assign out_last         = o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      origin_x_r  <= '0;
      tgt_org_x_r <= '0;
      tgt_org_y_r <= '0;
      tgt_cols_r  <= '0;
      tgt_rows_r  <= '0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      origin_x_r  <= origin_x_nxt;
      tgt_org_x_r <= tgt_org_x_nxt;
      tgt_org_y_r <= tgt_org_y_nxt;
      tgt_cols_r  <= tgt_cols_nxt;
      tgt_rows_r  <= tgt_rows_nxt;
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_status_r <= o_status_nxt;
    o_src_r    <= o_src_nxt;
    o_dst_r    <= o_dst_nxt;
    o_last_r   <= o_last_nxt;
  end

  // the raster counters stay inside the target rectangle while a blit runs
  a_cnt_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (col_cnt_r < tgt_cols_r) && (row_cnt_r < tgt_rows_r))
    else $error("raster counter outside target rectangle");

  // a blit only becomes active with finished step values
  a_commit_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> done_x && done_y)
    else $error("blit committed before step division finished");

endmodule

// ===== src/sbag_ctrl.sv =====
`timescale 1ns / 1ps
module sbag_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_mode,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbag_pkg::ctrl_cmd_t   cmd,
  input  sbag_pkg::dp_status_t  status
);
  import sbag_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   out_load;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !slot_free;
        if (in_valid && slot_free) begin
          priority if (!in_mode) begin
            cmd.advance = 1'b1;
          end else if (status.start_bad) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_DIVIDE;
          end
        end
      end
      S_DIVIDE: begin
        if (status.div_done && slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load      = cmd.advance || cmd.reject || cmd.commit;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_input_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVIDE |-> in_stall)
    else $error("input taken while steps are being divided");

  a_divide_started: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DIVIDE && !status.div_done)
    else $error("step division did not start after a start transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_valid_r |-> !out_stall)
    else $error("pending result overwritten");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sbag_pkg::*;

  // item kinds on the mode field
  localparam logic MODE_ADVANCE = 1'b0;
  localparam logic MODE_START   = 1'b1;

  localparam int MAX_GAP      = 12;
  // settling wait after the last result, sized from the step division of an accepted start
  localparam int BLIT_LATENCY = POS_W + 2;
  localparam int HOLD_CYCLES  = 150;
  localparam int MIX_PHASES   = 6;
  localparam int MIX_ITEMS    = 80;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [DIM_W-1:0]   dst_w;
    logic [DIM_W-1:0]   dst_h;
  } blit_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] source_index;
    logic [IDX_W-1:0] target_index;
    logic             last;
  } addr_pair_t;

  // every block input is known from time zero
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               in_mode       = MODE_ADVANCE;
  logic [COORD_W-1:0] in_rect_src_x = '0;
  logic [COORD_W-1:0] in_rect_src_y = '0;
  logic [DIM_W-1:0]   in_rect_src_w = '0;
  logic [DIM_W-1:0]   in_rect_src_h = '0;
  logic [COORD_W-1:0] in_rect_dst_x = '0;
  logic [COORD_W-1:0] in_rect_dst_y = '0;
  logic [DIM_W-1:0]   in_rect_dst_w = '0;
  logic [DIM_W-1:0]   in_rect_dst_h = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_source_index;
  logic [IDX_W-1:0] out_target_index;
  logic             out_last;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  scaled_blit_address_generator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_rect_src_x    (in_rect_src_x),
    .in_rect_src_y    (in_rect_src_y),
    .in_rect_src_w    (in_rect_src_w),
    .in_rect_src_h    (in_rect_src_h),
    .in_rect_dst_x    (in_rect_dst_x),
    .in_rect_dst_y    (in_rect_dst_y),
    .in_rect_dst_w    (in_rect_dst_w),
    .in_rect_dst_h    (in_rect_dst_h),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_source_index (out_source_index),
    .out_target_index (out_target_index),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // address predictor: its own copy of the texture registers and blit state
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]   tex_src_w, tex_src_h, tex_dst_w, tex_dst_h;
  logic               blit_busy;
  logic [POS_W-1:0]   step_x_fx, step_y_fx, pos_x_fx, pos_y_fx;
  logic [COORD_W-1:0] src_left, dst_left, dst_top;
  logic [DIM_W-1:0]   dst_cols, dst_rows, col_idx, row_idx;

  // address pairs predicted but not yet seen on the result channel
  addr_pair_t pending_pairs[$];

  int mismatches     = 0;
  int work_items     = 0;
  int starts_taken   = 0;
  int starts_refused = 0;
  int pairs_made     = 0;
  int idle_advances  = 0;
  int reg_writes     = 0;
  int settings_used  = 1;
  int cycle_count    = 0;

  bit tx_eager  = 1'b0;
  bit rx_eager  = 1'b0;
  logic long_hold = 1'b0;

  function automatic void reset_blit_state();
    tex_src_w = 11'd320;
    tex_src_h = 11'd240;
    tex_dst_w = 11'd320;
    tex_dst_h = 11'd240;
    blit_busy = 1'b0;
    step_x_fx = '0;
    step_y_fx = '0;
    pos_x_fx  = '0;
    pos_y_fx  = '0;
    src_left  = '0;
    dst_left  = '0;
    dst_top   = '0;
    dst_cols  = '0;
    dst_rows  = '0;
    col_idx   = '0;
    row_idx   = '0;
  endfunction

  function automatic addr_pair_t predict_pair(blit_cmd_t c);
    addr_pair_t  r;
    logic [31:0] src_right, src_bottom, dst_right, dst_bottom;
    logic [31:0] q, src_sum, dst_sum;
    r.status       = ST_NO_BLIT;
    r.source_index = '0;
    r.target_index = '0;
    r.last         = 1'b0;
    if (c.mode == MODE_START) begin
      src_right  = 32'(c.src_x) + 32'(c.src_w);
      src_bottom = 32'(c.src_y) + 32'(c.src_h);
      dst_right  = 32'(c.dst_x) + 32'(c.dst_w);
      dst_bottom = 32'(c.dst_y) + 32'(c.dst_h);
      if (src_right > 32'(tex_src_w) || src_bottom > 32'(tex_src_h) ||
          dst_right > 32'(tex_dst_w) || dst_bottom > 32'(tex_dst_h) ||
          c.dst_w == '0 || c.dst_h == '0) begin
        // a refused start also drops any blit in flight
        blit_busy = 1'b0;
        r.status  = ST_REJECT;
      end else begin
        q = (32'(c.src_w) << FRACTION_BITS) / 32'(c.dst_w);
        step_x_fx = q[POS_W-1:0];
        q = (32'(c.src_h) << FRACTION_BITS) / 32'(c.dst_h);
        step_y_fx = q[POS_W-1:0];
        q = 32'(c.src_x) << FRACTION_BITS;
        pos_x_fx = q[POS_W-1:0];
        q = 32'(c.src_y) << FRACTION_BITS;
        pos_y_fx = q[POS_W-1:0];
        src_left  = c.src_x;
        dst_left  = c.dst_x;
        dst_top   = c.dst_y;
        dst_cols  = c.dst_w;
        dst_rows  = c.dst_h;
        col_idx   = '0;
        row_idx   = '0;
        blit_busy = 1'b1;
        r.status  = ST_START_OK;
      end
    end else if (blit_busy) begin
      // source pixel is the floor of the accumulated position
      src_sum = (32'(pos_y_fx) >> FRACTION_BITS) * 32'(tex_src_w) +
                (32'(pos_x_fx) >> FRACTION_BITS);
      dst_sum = (32'(dst_top) + 32'(row_idx)) * 32'(tex_dst_w) +
                32'(dst_left) + 32'(col_idx);
      r.status       = ST_PAIR;
      r.source_index = src_sum[IDX_W-1:0];
      r.target_index = dst_sum[IDX_W-1:0];
      col_idx  = col_idx + 1'b1;
      pos_x_fx = pos_x_fx + step_x_fx;
      if (col_idx >= dst_cols) begin
        // end of a row: rewind x, step y
        col_idx  = '0;
        q        = 32'(src_left) << FRACTION_BITS;
        pos_x_fx = q[POS_W-1:0];
        row_idx  = row_idx + 1'b1;
        pos_y_fx = pos_y_fx + step_y_fx;
        if (row_idx >= dst_rows) begin
          blit_busy = 1'b0;
          r.last    = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // command sender
  // ---------------------------------------------------------------------------
  task automatic send_cmd(blit_cmd_t c);
    int         gap;
    addr_pair_t e;
    gap = tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= c.mode;
    in_rect_src_x <= c.src_x;
    in_rect_src_y <= c.src_y;
    in_rect_src_w <= c.src_w;
    in_rect_src_h <= c.src_h;
    in_rect_dst_x <= c.dst_x;
    in_rect_dst_y <= c.dst_y;
    in_rect_dst_w <= c.dst_w;
    in_rect_dst_h <= c.dst_h;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // transaction taken at this edge
    e = predict_pair(c);
    pending_pairs.push_back(e);
    case (e.status)
      ST_PAIR:     pairs_made++;
      ST_START_OK: starts_taken++;
      ST_REJECT:   starts_refused++;
      default:     idle_advances++;
    endcase
    if (e.status != ST_NO_BLIT) work_items++;
  endtask

  // drop valid and wait until the block has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (BLIT_LATENCY) @(posedge clk);
  endtask

  // random payload; on an advance the rectangle fields are don't-care
  function automatic blit_cmd_t noise_cmd(logic mode);
    blit_cmd_t c;
    c.mode  = mode;
    c.src_x = COORD_W'($urandom);
    c.src_y = COORD_W'($urandom);
    c.src_w = DIM_W'($urandom_range(0, MAX_DIMENSION));
    c.src_h = DIM_W'($urandom_range(0, MAX_DIMENSION));
    c.dst_x = COORD_W'($urandom);
    c.dst_y = COORD_W'($urandom);
    c.dst_w = DIM_W'($urandom_range(0, MAX_DIMENSION));
    c.dst_h = DIM_W'($urandom_range(0, MAX_DIMENSION));
    return c;
  endfunction

  function automatic blit_cmd_t start_cmd(int sx, int sy, int sw, int sh,
                                          int dx, int dy, int dw, int dh);
    blit_cmd_t c;
    c.mode  = MODE_START;
    c.src_x = COORD_W'(sx);
    c.src_y = COORD_W'(sy);
    c.src_w = DIM_W'(sw);
    c.src_h = DIM_W'(sh);
    c.dst_x = COORD_W'(dx);
    c.dst_y = COORD_W'(dy);
    c.dst_w = DIM_W'(dw);
    c.dst_h = DIM_W'(dh);
    return c;
  endfunction

  // extent in 0..lim, mostly no larger than cap, sometimes the full texture
  function automatic int pick_extent(int lim, int cap);
    int r;
    r = $urandom_range(0, 9);
    if (lim <= 0) return 0;
    if (r == 0) return lim;
    if (r < 3) return $urandom_range(0, lim);
    return $urandom_range(0, (lim < cap) ? lim : cap);
  endfunction

  // a start whose rectangles fit the current textures; target must be non-empty
  function automatic blit_cmd_t fitted_start(int max_cols, int max_rows);
    blit_cmd_t c;
    int tsw, tsh, tdw, tdh, sw, sh, dw, dh, room;
    tsw = int'(tex_src_w);
    tsh = int'(tex_src_h);
    tdw = int'(tex_dst_w);
    tdh = int'(tex_dst_h);
    c  = noise_cmd(MODE_START);
    sw = pick_extent(tsw, 64);
    sh = pick_extent(tsh, 64);
    dw = 1 + $urandom_range(0, ((tdw < max_cols) ? tdw : max_cols) - 1);
    dh = 1 + $urandom_range(0, ((tdh < max_rows) ? tdh : max_rows) - 1);
    c.src_w = DIM_W'(sw);
    c.src_h = DIM_W'(sh);
    c.dst_w = DIM_W'(dw);
    c.dst_h = DIM_W'(dh);
    room = tsw - sw;
    c.src_x = COORD_W'($urandom_range(0, (room > 1023) ? 1023 : room));
    room = tsh - sh;
    c.src_y = COORD_W'($urandom_range(0, (room > 1023) ? 1023 : room));
    room = tdw - dw;
    c.dst_x = COORD_W'($urandom_range(0, (room > 1023) ? 1023 : room));
    room = tdh - dh;
    c.dst_y = COORD_W'($urandom_range(0, (room > 1023) ? 1023 : room));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker with random output stalls
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  int         hold_left = 0;
  addr_pair_t want_pair;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d",
                 $time, out_status);
        mismatches++;
      end else begin
        want_pair = pending_pairs.pop_front();
        compare_field("status", 32'(want_pair.status), 32'(out_status));
        compare_field("source_index", 32'(want_pair.source_index),
                      32'(out_source_index));
        compare_field("target_index", 32'(want_pair.target_index),
                      32'(out_target_index));
        compare_field("last", 32'(want_pair.last), 32'(out_last));
      end
      hold_left = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
    end else if (out_valid === 1'b1 && hold_left > 0) begin
      // stall cycles only count while a result is waiting
      hold_left = hold_left - 1;
    end
    out_stall <= long_hold || (hold_left > 0);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_pairs.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register port: write then read back
  // ---------------------------------------------------------------------------
  task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] data);
    logic [DIM_W-1:0]   kept;
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    // only the low 11 bits count, anything above the max dimension clamps
    kept = data[DIM_W-1:0];
    if (kept > DIM_W'(MAX_DIMENSION)) kept = DIM_W'(MAX_DIMENSION);
    case (idx)
      REG_SRC_TEX_W: tex_src_w = kept;
      REG_SRC_TEX_H: tex_src_h = kept;
      REG_DST_TEX_W: tex_dst_w = kept;
      default:       tex_dst_h = kept;
    endcase
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    readback = '0;
    readback[DIM_W-1:0] = kept;
    compare_field("register readback", readback, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_textures(logic [PDATA_W-1:0] sw, logic [PDATA_W-1:0] sh,
                                    logic [PDATA_W-1:0] dw, logic [PDATA_W-1:0] dh);
    settle();
    write_register(REG_SRC_TEX_W, sw);
    write_register(REG_SRC_TEX_H, sh);
    write_register(REG_DST_TEX_W, dw);
    write_register(REG_DST_TEX_H, dh);
    settings_used++;
  endtask

  // random register word: mostly legal sizes, sometimes zero or above the clamp
  function automatic logic [PDATA_W-1:0] random_extent_word();
    logic [PDATA_W-1:0] w;
    int r;
    r = $urandom_range(0, 19);
    w = $urandom;
    if (r == 0) w[DIM_W-1:0] = '0;
    else if (r == 1) w[DIM_W-1:0] = DIM_W'($urandom_range(MAX_DIMENSION + 1, 2047));
    else if (r == 2) w[DIM_W-1:0] = DIM_W'(MAX_DIMENSION);
    else if (r < 10) w[DIM_W-1:0] = DIM_W'($urandom_range(1, 32));
    else w[DIM_W-1:0] = DIM_W'($urandom_range(1, MAX_DIMENSION));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle advance and refused starts (zero target size, source or target past an edge), at reset texture sizes
  task automatic test_idle_and_rejects();
    send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(0, 0, 0, 4, 5, 5, 0, 3));        // zero target width
    send_cmd(start_cmd(0, 0, 4, 4, 5, 5, 3, 0));        // zero target height
    send_cmd(start_cmd(300, 0, 21, 4, 0, 0, 2, 2));     // source past right edge
    send_cmd(start_cmd(0, 0, 4, 4, 0, 200, 2, 41));     // target past bottom edge
  endtask

  // equal-size copy, zero source size, restart and refusal while busy
  task automatic test_copy_and_restart();
    send_cmd(start_cmd(10, 20, 3, 2, 100, 50, 3, 2));   // step of exactly one pixel
    repeat (6) send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(7, 9, 0, 0, 0, 0, 2, 2));        // every pixel reads one spot
    send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(319, 239, 1, 1, 318, 238, 2, 2));  // restart mid blit, upscale
    repeat (2) send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(0, 0, 1024, 1, 0, 0, 1, 1));     // refusal ends the blit
    send_cmd(noise_cmd(MODE_ADVANCE));
  endtask

  // largest and smallest texture settings
  task automatic test_register_extremes();
    configure_textures(32'd2047, 32'd1024, 32'd1025, 32'd1024);
    send_cmd(start_cmd(0, 0, 1024, 1024, 1023, 1023, 1, 1));  // top index of the map
    send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(1023, 1023, 1, 1, 0, 0, 1024, 1));     // step truncates to zero
    repeat (2) send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(1023, 0, 2, 1, 0, 0, 1, 1024));        // one column too far
    configure_textures(32'd1, 32'd1, 32'd1, 32'd1);
    send_cmd(start_cmd(0, 0, 1, 1, 0, 0, 1, 1));
    send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(0, 0, 1, 0, 1, 0, 1, 1));
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_output_backpressure();
    configure_textures(32'd320, 32'd240, 32'd320, 32'd240);
    fork
      begin
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
      end
    join_none
    tx_eager = 1'b1;
    send_cmd(start_cmd(8, 4, 16, 8, 20, 30, 8, 4));
    repeat (32) send_cmd(noise_cmd(MODE_ADVANCE));
    send_cmd(start_cmd(0, 0, 5, 3, 0, 0, 7, 5));
    repeat (20) send_cmd(noise_cmd(MODE_ADVANCE));
    tx_eager = 1'b0;
  endtask

  // mostly complete blits with random content, some cut short or overrun,
  // plus random starts and stray advances
  task automatic run_blit_mix(int target);
    blit_cmd_t c;
    int first, r, k, pixels, n;
    first = work_items;
    while (work_items - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 75 && tex_dst_w != '0 && tex_dst_h != '0) begin
        c = fitted_start((r < 5) ? 64 : 10, (r < 5) ? 1 : 5);
        send_cmd(c);
        pixels = int'(c.dst_w) * int'(c.dst_h);
        n = pixels;
        k = $urandom_range(0, 9);
        if (k == 0) n = $urandom_range(0, pixels);
        else if (k == 1) n = pixels + $urandom_range(1, 3);
        repeat (n) send_cmd(noise_cmd(MODE_ADVANCE));
      end else if (r < 90) begin
        send_cmd(noise_cmd(MODE_START));
        repeat ($urandom_range(0, 3)) send_cmd(noise_cmd(MODE_ADVANCE));
      end else begin
        repeat ($urandom_range(1, 3)) send_cmd(noise_cmd(MODE_ADVANCE));
      end
    end
  endtask

  task automatic test_random_settings();
    int p;
    for (p = 0; p < MIX_PHASES; p++) begin
      configure_textures(random_extent_word(), random_extent_word(),
                         random_extent_word(), random_extent_word());
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      run_blit_mix(MIX_ITEMS);
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  initial begin
    reset_blit_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_and_rejects();
    test_copy_and_restart();
    test_register_extremes();
    test_output_backpressure();
    test_random_settings();
    settle();
    $display("covered %0d accepted starts, %0d refused starts, %0d address pairs,",
             starts_taken, starts_refused, pairs_made);
    $display("%0d idle advances, %0d texture settings, %0d register writes, %0d mismatches",
             idle_advances, settings_used, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sbag_pkg.sv
src/sbag_regs.sv
src/sbag_div.sv
src/sbag_dp.sv
src/sbag_ctrl.sv
src/scaled_blit_address_generator_unit.sv
verif/tb_top.sv
